>>> rtl/nec_ird_pkg.sv
`timescale 1ns / 1ps

package nec_ird_pkg;

	// Default sizes handed to the top level.
	localparam int FRAME_BYTES_DEF = 4;
	localparam int COUNT_BITS_DEF  = 12;

	// Configuration register layout.
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;

	localparam cfg_idx_t REG_LEADER_LOW_MIN  = 3'd0;
	localparam cfg_idx_t REG_LEADER_LOW_MAX  = 3'd1;
	localparam cfg_idx_t REG_LEADER_HIGH_MAX = 3'd2;
	localparam cfg_idx_t REG_BIT_LOW_MAX     = 3'd3;
	localparam cfg_idx_t REG_BIT_HIGH_MAX    = 3'd4;
	localparam cfg_idx_t REG_ONE_THRESHOLD   = 3'd5;

	// Register values after reset.
	localparam cfg_val_t RST_LEADER_LOW_MIN  = 12'd700;
	localparam cfg_val_t RST_LEADER_LOW_MAX  = 12'd1000;
	localparam cfg_val_t RST_LEADER_HIGH_MAX = 12'd500;
	localparam cfg_val_t RST_BIT_LOW_MAX     = 12'd60;
	localparam cfg_val_t RST_BIT_HIGH_MAX    = 12'd300;
	localparam cfg_val_t RST_ONE_THRESHOLD   = 12'd80;

	// Frame status codes.
	typedef logic [1:0] status_t;

	localparam status_t STATUS_GOOD    = 2'd0;
	localparam status_t STATUS_CHECK   = 2'd1;
	localparam status_t STATUS_TIMEOUT = 2'd2;

	typedef logic [7:0] byte_t;

endpackage

>>> rtl/nec_ird_if.sv
`timescale 1ns / 1ps

// Receiver pin samples, one per request.
interface nec_ird_in_if;
	logic valid;
	logic ready;
	logic ir_level;

	modport source (output valid, output ir_level, input ready);
	modport sink (input valid, input ir_level, output ready);
endinterface

// Decoded frames, one per request.
interface nec_ird_out_if;
	logic                  valid;
	logic                  ready;
	nec_ird_pkg::byte_t    address;
	nec_ird_pkg::byte_t    address_inverse;
	nec_ird_pkg::byte_t    command;
	nec_ird_pkg::byte_t    command_inverse;
	nec_ird_pkg::status_t  status;

	modport source (
		output valid, output address, output address_inverse,
		output command, output command_inverse, output status,
		input ready
	);
	modport sink (
		input valid, input address, input address_inverse,
		input command, input command_inverse, input status,
		output ready
	);
endinterface

// Configuration register writes.
interface nec_ird_cfg_if;
	logic                  valid;
	logic                  ready;
	nec_ird_pkg::cfg_idx_t index;
	nec_ird_pkg::cfg_val_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/nec_infrared_frame_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Request carries
// ir        in         ir_level, one pin sample per tick
// frame     out        address, address_inverse, command, command_inverse, status
// cfg       in         index and data of one timing register write
//
// One pin sample is accepted per cycle; phase, tick counter and shift register
// update on the accepting edge, and a finished frame lands in the output
// register on that same edge, so a result is offered in the cycle after its sample.
// Sample intake stalls only while a frame waits and the sink is not ready.
// Configuration writes are always taken.
// Reset loads the default timings and leaves the decoder idle, line assumed high.

module nec_infrared_frame_decoder #(
	parameter int FRAME_BYTES = nec_ird_pkg::FRAME_BYTES_DEF,
	parameter int COUNT_BITS  = nec_ird_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	nec_ird_in_if.sink           ir,
	nec_ird_out_if.source        frame,
	nec_ird_cfg_if.sink          cfg
);

	localparam int FRAME_BITS = FRAME_BYTES * 8;
	localparam int IDX_W      = $clog2(FRAME_BITS);
	localparam int CMP_W      = (COUNT_BITS > nec_ird_pkg::CFG_W) ?
	                            COUNT_BITS : nec_ird_pkg::CFG_W;
	localparam int PAD_W      = (FRAME_BITS > 32) ? FRAME_BITS : 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam logic [IDX_W-1:0]      LAST_BIT  = IDX_W'(FRAME_BITS - 1);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_LEAD_LOW  = 3'd1;
	localparam logic [2:0] PH_LEAD_HIGH = 3'd2;
	localparam logic [2:0] PH_BIT_LOW   = 3'd3;
	localparam logic [2:0] PH_BIT_HIGH  = 3'd4;

	// Timing registers.
	nec_ird_pkg::cfg_val_t leader_low_min_q;
	nec_ird_pkg::cfg_val_t leader_low_max_q;
	nec_ird_pkg::cfg_val_t leader_high_max_q;
	nec_ird_pkg::cfg_val_t bit_low_max_q;
	nec_ird_pkg::cfg_val_t bit_high_max_q;
	nec_ird_pkg::cfg_val_t one_threshold_q;

	// Decoder state.
	logic [2:0]            phase_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [IDX_W-1:0]      bit_idx_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic                  prev_level_q;

	// Output register.
	logic                  out_valid_q;
	nec_ird_pkg::byte_t    address_q;
	nec_ird_pkg::byte_t    address_inverse_q;
	nec_ird_pkg::byte_t    command_q;
	nec_ird_pkg::byte_t    command_inverse_q;
	nec_ird_pkg::status_t  status_q;

	logic                  accept;
	logic [COUNT_BITS-1:0] count_inc;
	logic [CMP_W-1:0]      count_ext;
	logic [CMP_W-1:0]      inc_ext;
	logic [FRAME_BITS-1:0] shift_next;
	logic [PAD_W-1:0]      frame_pad;
	nec_ird_pkg::byte_t    cmd_byte;
	nec_ird_pkg::byte_t    inv_byte;

	logic [2:0]            phase_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [IDX_W-1:0]      bit_idx_d;
	logic [FRAME_BITS-1:0] shift_d;
	logic                  emit_timeout;
	logic                  emit_frame;

	assign accept   = ir.valid && ir.ready;
	assign ir.ready = !out_valid_q || frame.ready;
	assign cfg.ready = 1'b1;

	// Saturating tick count and widened copies for the limit compares.
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;
	assign count_ext = CMP_W'(count_q);
	assign inc_ext   = CMP_W'(count_inc);

	// Bits arrive least significant first, so they enter at the top and move down.
	assign shift_next = {(count_ext >= CMP_W'(one_threshold_q)),
	                     shift_q[FRAME_BITS-1:1]};
	assign frame_pad  = PAD_W'(shift_next);
	assign cmd_byte   = frame_pad[23:16];
	assign inv_byte   = frame_pad[31:24];

	// Next state for one sample.
	always_comb begin
		phase_d      = phase_q;
		count_d      = count_q;
		bit_idx_d    = bit_idx_q;
		shift_d      = shift_q;
		emit_timeout = 1'b0;
		emit_frame   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (prev_level_q && !ir.ir_level) begin
					phase_d = PH_LEAD_LOW;
					count_d = COUNT_ONE;
				end
			end
			PH_LEAD_LOW: begin
				if (!ir.ir_level) begin
					count_d = count_inc;
					if (inc_ext > CMP_W'(leader_low_max_q)) begin
						emit_timeout = 1'b1;
					end
				end else if (count_ext >= CMP_W'(leader_low_min_q)) begin
					phase_d = PH_LEAD_HIGH;
					count_d = COUNT_ONE;
				end else begin
					phase_d = PH_IDLE;
					count_d = '0;
				end
			end
			PH_LEAD_HIGH: begin
				if (ir.ir_level) begin
					count_d = count_inc;
					if (inc_ext > CMP_W'(leader_high_max_q)) begin
						emit_timeout = 1'b1;
					end
				end else begin
					phase_d   = PH_BIT_LOW;
					count_d   = COUNT_ONE;
					bit_idx_d = '0;
				end
			end
			PH_BIT_LOW: begin
				if (!ir.ir_level) begin
					count_d = count_inc;
					if (inc_ext > CMP_W'(bit_low_max_q)) begin
						emit_timeout = 1'b1;
					end
				end else begin
					phase_d = PH_BIT_HIGH;
					count_d = COUNT_ONE;
				end
			end
			PH_BIT_HIGH: begin
				if (ir.ir_level) begin
					count_d = count_inc;
					if (inc_ext > CMP_W'(bit_high_max_q)) begin
						emit_timeout = 1'b1;
					end
				end else begin
					shift_d = shift_next;
					if (bit_idx_q == LAST_BIT) begin
						emit_frame = 1'b1;
					end else begin
						bit_idx_d = bit_idx_q + IDX_W'(1);
						phase_d   = PH_BIT_LOW;
						count_d   = COUNT_ONE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				count_d = '0;
			end
		endcase
		// A result of either kind sends the decoder back to idle.
		if (emit_timeout || emit_frame) begin
			phase_d   = PH_IDLE;
			count_d   = '0;
			bit_idx_d = '0;
		end
	end

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			count_q      <= '0;
			bit_idx_q    <= '0;
			prev_level_q <= 1'b1;
		end else if (accept) begin
			phase_q      <= phase_d;
			count_q      <= count_d;
			bit_idx_q    <= bit_idx_d;
			prev_level_q <= ir.ir_level;
		end
	end

	// Every bit of the frame is overwritten before it is reported.
	always_ff @(posedge clk) begin
		if (accept) begin
			shift_q <= shift_d;
		end
	end

	// Timing register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_low_min_q  <= nec_ird_pkg::RST_LEADER_LOW_MIN;
			leader_low_max_q  <= nec_ird_pkg::RST_LEADER_LOW_MAX;
			leader_high_max_q <= nec_ird_pkg::RST_LEADER_HIGH_MAX;
			bit_low_max_q     <= nec_ird_pkg::RST_BIT_LOW_MAX;
			bit_high_max_q    <= nec_ird_pkg::RST_BIT_HIGH_MAX;
			one_threshold_q   <= nec_ird_pkg::RST_ONE_THRESHOLD;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				nec_ird_pkg::REG_LEADER_LOW_MIN:  leader_low_min_q  <= cfg.data;
				nec_ird_pkg::REG_LEADER_LOW_MAX:  leader_low_max_q  <= cfg.data;
				nec_ird_pkg::REG_LEADER_HIGH_MAX: leader_high_max_q <= cfg.data;
				nec_ird_pkg::REG_BIT_LOW_MAX:     bit_low_max_q     <= cfg.data;
				nec_ird_pkg::REG_BIT_HIGH_MAX:    bit_high_max_q    <= cfg.data;
				nec_ird_pkg::REG_ONE_THRESHOLD:   one_threshold_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (emit_timeout || emit_frame)) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; a timeout reports zero bytes.
	always_ff @(posedge clk) begin
		if (accept && emit_timeout) begin
			address_q         <= '0;
			address_inverse_q <= '0;
			command_q         <= '0;
			command_inverse_q <= '0;
			status_q          <= nec_ird_pkg::STATUS_TIMEOUT;
		end else if (accept && emit_frame) begin
			address_q         <= frame_pad[7:0];
			address_inverse_q <= frame_pad[15:8];
			command_q         <= cmd_byte;
			command_inverse_q <= inv_byte;
			status_q          <= (cmd_byte == ~inv_byte) ?
			                     nec_ird_pkg::STATUS_GOOD : nec_ird_pkg::STATUS_CHECK;
		end
	end

	assign frame.valid           = out_valid_q;
	assign frame.address         = address_q;
	assign frame.address_inverse = address_inverse_q;
	assign frame.command         = command_q;
	assign frame.command_inverse = command_inverse_q;
	assign frame.status          = status_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int FRAME_BITS      = 32;
	localparam int RANDOM_SAMPLES  = 500;

	// Phases of the decoder as the predictor tracks them.
	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_LEAD_LOW,
		DEC_LEAD_HIGH,
		DEC_BIT_LOW,
		DEC_BIT_HIGH
	} dec_phase_t;

	typedef struct packed {
		nec_ird_pkg::byte_t   address;
		nec_ird_pkg::byte_t   address_inverse;
		nec_ird_pkg::byte_t   command;
		nec_ird_pkg::byte_t   command_inverse;
		nec_ird_pkg::status_t status;
	} frame_t;

	logic clk;
	logic arst_n;

	nec_ird_in_if  ir_if ();
	nec_ird_out_if frame_if ();
	nec_ird_cfg_if cfg_if ();

	nec_infrared_frame_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.ir     (ir_if),
		.frame  (frame_if),
		.cfg    (cfg_if)
	);

	// Mirror of the timing registers and of the decoder state.
	nec_ird_pkg::cfg_val_t timing [0:5];
	dec_phase_t            dec_phase;
	nec_ird_pkg::cfg_val_t tick_cnt;
	logic [5:0]            bit_idx;
	logic [31:0]           frame_bits;
	logic                  line_prev;

	frame_t expected_frames [$];

	int  error_count;
	int  samples_sent;
	int  frames_checked;
	int  good_seen;
	int  check_seen;
	int  timeout_seen;
	int  gap_pct;
	int  stall_pct;
	bit  hold_off_pending;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Decoder state returns to idle without touching the remembered line level.
	function automatic void clear_decoder();
		dec_phase  = DEC_IDLE;
		tick_cnt   = '0;
		bit_idx    = '0;
		frame_bits = '0;
	endfunction

	function automatic void reset_model();
		timing[nec_ird_pkg::REG_LEADER_LOW_MIN]  = nec_ird_pkg::RST_LEADER_LOW_MIN;
		timing[nec_ird_pkg::REG_LEADER_LOW_MAX]  = nec_ird_pkg::RST_LEADER_LOW_MAX;
		timing[nec_ird_pkg::REG_LEADER_HIGH_MAX] = nec_ird_pkg::RST_LEADER_HIGH_MAX;
		timing[nec_ird_pkg::REG_BIT_LOW_MAX]     = nec_ird_pkg::RST_BIT_LOW_MAX;
		timing[nec_ird_pkg::REG_BIT_HIGH_MAX]    = nec_ird_pkg::RST_BIT_HIGH_MAX;
		timing[nec_ird_pkg::REG_ONE_THRESHOLD]   = nec_ird_pkg::RST_ONE_THRESHOLD;
		clear_decoder();
		line_prev = 1'b1;
	endfunction

	// Advances the decoder by one pin sample; returns 1 when a frame result is due.
	function automatic bit decode_sample(input logic lvl, output frame_t res);
		logic               was;
		bit                 hit;
		nec_ird_pkg::byte_t inv_cmd;
		was       = line_prev;
		line_prev = lvl;
		hit       = 1'b0;
		res       = '0;
		case (dec_phase)
			DEC_IDLE: begin
				if (was && !lvl) begin
					dec_phase = DEC_LEAD_LOW;
					tick_cnt  = 1;
				end
			end
			DEC_LEAD_LOW: begin
				if (!lvl) begin
					if (tick_cnt != '1)
						tick_cnt++;
					if (tick_cnt > timing[nec_ird_pkg::REG_LEADER_LOW_MAX])
						hit = 1'b1;
				end else if (tick_cnt >= timing[nec_ird_pkg::REG_LEADER_LOW_MIN]) begin
					dec_phase = DEC_LEAD_HIGH;
					tick_cnt  = 1;
				end else begin
					clear_decoder();
				end
			end
			DEC_LEAD_HIGH: begin
				if (lvl) begin
					if (tick_cnt != '1)
						tick_cnt++;
					if (tick_cnt > timing[nec_ird_pkg::REG_LEADER_HIGH_MAX])
						hit = 1'b1;
				end else begin
					dec_phase  = DEC_BIT_LOW;
					tick_cnt   = 1;
					bit_idx    = '0;
					frame_bits = '0;
				end
			end
			DEC_BIT_LOW: begin
				if (!lvl) begin
					if (tick_cnt != '1)
						tick_cnt++;
					if (tick_cnt > timing[nec_ird_pkg::REG_BIT_LOW_MAX])
						hit = 1'b1;
				end else begin
					dec_phase = DEC_BIT_HIGH;
					tick_cnt  = 1;
				end
			end
			DEC_BIT_HIGH: begin
				if (lvl) begin
					if (tick_cnt != '1)
						tick_cnt++;
					if (tick_cnt > timing[nec_ird_pkg::REG_BIT_HIGH_MAX])
						hit = 1'b1;
				end else begin
					if (tick_cnt >= timing[nec_ird_pkg::REG_ONE_THRESHOLD])
						frame_bits[bit_idx[4:0]] = 1'b1;
					if (bit_idx == FRAME_BITS - 1) begin
						res.address         = frame_bits[7:0];
						res.address_inverse = frame_bits[15:8];
						res.command         = frame_bits[23:16];
						res.command_inverse = frame_bits[31:24];
						inv_cmd             = ~frame_bits[31:24];
						res.status = (res.command == inv_cmd) ?
							nec_ird_pkg::STATUS_GOOD : nec_ird_pkg::STATUS_CHECK;
						clear_decoder();
						return 1'b1;
					end
					bit_idx++;
					dec_phase = DEC_BIT_LOW;
					tick_cnt  = 1;
				end
			end
			default: clear_decoder();
		endcase
		// Every timeout leaves the byte fields at zero.
		if (hit) begin
			res.status = nec_ird_pkg::STATUS_TIMEOUT;
			clear_decoder();
		end
		return hit;
	endfunction

	// Offers one pin sample and waits until the request is taken.
	task automatic send_sample(input logic lvl);
		bit     took;
		frame_t res;
		while ($urandom_range(99) < gap_pct) begin
			ir_if.valid <= 1'b0;
			@(posedge clk);
		end
		ir_if.valid    <= 1'b1;
		ir_if.ir_level <= lvl;
		do begin
			@(negedge clk);
			took = ir_if.ready;
			if (took) begin
				samples_sent++;
				if (decode_sample(lvl, res))
					expected_frames.push_back(res);
			end
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_run(input logic lvl, input int len);
		repeat (len) send_sample(lvl);
	endtask

	// Random length in a range, kept short so that frames stay quick.
	function automatic int pick(input int lo, input int hi);
		if (hi > lo + 3)
			hi = lo + 3;
		if (hi < lo)
			hi = lo;
		return $urandom_range(hi, lo);
	endfunction

	// Lets the last requests drain before anything is reconfigured.
	task automatic wait_drained();
		ir_if.valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input nec_ird_pkg::cfg_idx_t idx,
			input nec_ird_pkg::cfg_val_t val);
		bit took;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do begin
			@(negedge clk);
			took = cfg_if.ready;
			@(posedge clk);
		end while (!took);
		timing[idx] = val;
	endtask

	task automatic set_timing(input nec_ird_pkg::cfg_val_t lo_min,
			input nec_ird_pkg::cfg_val_t lo_max, input nec_ird_pkg::cfg_val_t hi_max,
			input nec_ird_pkg::cfg_val_t b_lo_max, input nec_ird_pkg::cfg_val_t b_hi_max,
			input nec_ird_pkg::cfg_val_t thr);
		wait_drained();
		write_reg(nec_ird_pkg::REG_LEADER_LOW_MIN, lo_min);
		write_reg(nec_ird_pkg::REG_LEADER_LOW_MAX, lo_max);
		write_reg(nec_ird_pkg::REG_LEADER_HIGH_MAX, hi_max);
		write_reg(nec_ird_pkg::REG_BIT_LOW_MAX, b_lo_max);
		write_reg(nec_ird_pkg::REG_BIT_HIGH_MAX, b_hi_max);
		write_reg(nec_ird_pkg::REG_ONE_THRESHOLD, thr);
		cfg_if.valid <= 1'b0;
	endtask

	// Sends one NEC frame; a non-negative abort_bit overruns that bit's mark or space.
	// A lead_len of zero picks a leader length inside the configured window.
	task automatic send_frame(input logic [31:0] data, input int abort_bit,
			input int lead_len);
		bit aborted;
		int thr;
		int b_hi_max;
		aborted  = 1'b0;
		thr      = timing[nec_ird_pkg::REG_ONE_THRESHOLD];
		b_hi_max = timing[nec_ird_pkg::REG_BIT_HIGH_MAX];
		send_run(1'b1, $urandom_range(3, 1));
		send_run(1'b0, (lead_len > 0) ? lead_len :
			pick(timing[nec_ird_pkg::REG_LEADER_LOW_MIN],
				timing[nec_ird_pkg::REG_LEADER_LOW_MAX]));
		send_run(1'b1, pick(1, timing[nec_ird_pkg::REG_LEADER_HIGH_MAX]));
		for (int b = 0; b < FRAME_BITS && !aborted; b++) begin
			if (b == abort_bit) begin
				if ($urandom_range(1)) begin
					send_run(1'b0, timing[nec_ird_pkg::REG_BIT_LOW_MAX] + 1 +
						$urandom_range(2));
				end else begin
					send_run(1'b0, 1);
					send_run(1'b1, b_hi_max + 1 + $urandom_range(2));
				end
				aborted = 1'b1;
			end else begin
				send_run(1'b0, pick(1, timing[nec_ird_pkg::REG_BIT_LOW_MAX]));
				send_run(1'b1, data[b] ? pick(thr, b_hi_max) : pick(1, thr - 1));
			end
		end
		// Stop mark: its falling edge ends the last space.
		if (!aborted)
			send_run(1'b0, $urandom_range(2, 1));
	endtask

	// Mostly well-formed frames with random content, the rest broken or noise.
	task automatic send_random_item();
		int                 pct;
		nec_ird_pkg::byte_t addr;
		nec_ird_pkg::byte_t cmd;
		pct  = $urandom_range(99);
		addr = $urandom;
		cmd  = $urandom;
		if (pct < 70) begin
			send_frame({~cmd, cmd, ~addr, addr}, -1, 0);
		end else if (pct < 85) begin
			send_frame({~cmd, cmd, ~addr, addr}, $urandom_range(FRAME_BITS - 1), 0);
		end else if (pct < 93) begin
			send_frame($urandom, -1, 0);
		end else begin
			repeat ($urandom_range(6, 1))
				send_run($urandom_range(1), $urandom_range(10, 1));
		end
	endtask

	task automatic random_timing();
		int lo_min;
		int thr;
		lo_min = $urandom_range(4, 1);
		thr    = $urandom_range(4, 2);
		set_timing(lo_min, lo_min + $urandom_range(4), $urandom_range(4, 1),
			$urandom_range(3, 1), thr + $urandom_range(3), thr);
	endtask

	task automatic test_reset_timing();
		// A short low straight after reset is only a glitch at the default leader length.
		send_run(1'b0, 3);
		send_run(1'b1, 2);
		// A leader of the default minimum length, then a bit mark just past its default limit.
		send_run(1'b0, nec_ird_pkg::RST_LEADER_LOW_MIN);
		send_run(1'b1, 3);
		send_run(1'b0, nec_ird_pkg::RST_BIT_LOW_MAX + 1);
		// The line stays low: no new frame may start until it goes high.
		send_run(1'b0, 5);
	endtask

	task automatic test_tight_limits();
		set_timing(1, 1, 1, 1, 2, 2);
		send_frame(32'hFF00_FF00, -1, 0);
		send_frame(32'h5AA5_C33C, -1, 0);
		send_frame(32'hFFFF_FFFF, -1, 0);
		// Leader low overrun.
		send_run(1'b1, 1);
		send_run(1'b0, 3);
		// Leader high overrun.
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 3);
		// Repeat burst: leader, one mark, then a space that never ends in time.
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 4);
		// Bit mark overrun.
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 3);
		// Leader shorter than the minimum is dropped silently.
		set_timing(3, 5, 1, 1, 2, 2);
		send_run(1'b1, 1);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
	endtask

	task automatic test_random_traffic();
		int first_sample;
		int count;
		first_sample = samples_sent;
		count        = 0;
		while (samples_sent - first_sample < RANDOM_SAMPLES) begin
			if (count % 6 == 0)
				random_timing();
			send_random_item();
			count++;
		end
	endtask

	task automatic test_no_idling();
		gap_pct   = 0;
		stall_pct = 0;
		random_timing();
		repeat (2) send_random_item();
		gap_pct   = 25;
		stall_pct = 25;
	endtask

	task automatic test_back_pressure();
		set_timing(1, 2, 2, 1, 2, 2);
		hold_off_pending = 1'b1;
		// Leader overruns give a result every few samples, so the output fills quickly.
		repeat (30) begin
			send_run(1'b1, 1);
			send_run(1'b0, 4);
		end
	endtask

	// Receiver side: random stalls, plus a long hold-off when one is requested.
	initial begin : frame_receiver
		int held;
		frame_if.ready = 1'b0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				held = HOLD_OFF_CYCLES;
			end
			if (held > 0) begin
				held--;
				frame_if.ready <= 1'b0;
			end else begin
				frame_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic check_field(input string what, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
			error_count++;
		end
	endtask

	// Each accepted request on the frame channel is compared with the oldest expected frame.
	always @(negedge clk) begin : frame_checker
		frame_t want;
		if (arst_n && frame_if.valid && frame_if.ready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t ns: frame with no expectation, expected none, got %0h %0h %0h %0h %0h",
					$time, frame_if.address, frame_if.address_inverse, frame_if.command,
					frame_if.command_inverse, frame_if.status);
				error_count++;
			end else begin
				want = expected_frames.pop_front();
				check_field("address", want.address, frame_if.address);
				check_field("address_inverse", want.address_inverse, frame_if.address_inverse);
				check_field("command", want.command, frame_if.command);
				check_field("command_inverse", want.command_inverse, frame_if.command_inverse);
				check_field("status", want.status, frame_if.status);
				frames_checked++;
				case (want.status)
					nec_ird_pkg::STATUS_GOOD:  good_seen++;
					nec_ird_pkg::STATUS_CHECK: check_seen++;
					default:                   timeout_seen++;
				endcase
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		ir_if.valid      = 1'b0;
		ir_if.ir_level   = 1'b1;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = nec_ird_pkg::REG_LEADER_LOW_MIN;
		cfg_if.data      = '0;
		hold_off_pending = 1'b0;
		gap_pct          = 25;
		stall_pct        = 25;
		error_count      = 0;
		samples_sent     = 0;
		frames_checked   = 0;
		good_seen        = 0;
		check_seen       = 0;
		timeout_seen     = 0;
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_tight_limits();
		test_random_traffic();
		test_no_idling();
		test_back_pressure();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Run covered %0d pin samples and %0d decoded frames:", samples_sent,
			frames_checked);
		$display("  %0d good, %0d with a failed command check, %0d aborted by a timeout.",
			good_seen, check_seen, timeout_seen);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
